[sv/downmix_linear_resampler_unit_defines.svh]
// Assertion macros shared by the RTL of the downmix resampler.
`ifndef DOWNMIX_LINEAR_RESAMPLER_UNIT_DEFINES_SVH
`define DOWNMIX_LINEAR_RESAMPLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DLR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DLR_ASSERT(lbl, clk, rst_n, prop, msg)
`define DLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[sv/dlr_pkg.sv]
`default_nettype none

package dlr_pkg;

	localparam int CNT_W     = 4;
	localparam int RECIP_W   = 17;
	localparam int STEP_W    = 20;
	localparam int PHASE_W   = 20;
	localparam int FRAC_BITS = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = STEP_W;

	localparam logic [STEP_W-1:0]  STEP_MIN    = 20'd4096;
	localparam logic [STEP_W-1:0]  STEP_MAX    = 20'd524288;
	localparam logic [PHASE_W-1:0] ONE_Q16     = 20'h10000;
	localparam logic [CNT_W-1:0]   CNT_RESET   = 4'd1;
	localparam logic [RECIP_W-1:0] RECIP_RESET = 17'h10000;
	localparam logic [STEP_W-1:0]  STEP_RESET  = 20'h10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANNEL_COUNT,
		CFG_DOWNMIX_RECIP,
		CFG_RESAMPLE_STEP
	} dlr_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MONO_MUL,
		ST_MONO_SAT,
		ST_INT_MUL,
		ST_INT_OUT
	} dlr_state_t;

	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic [RECIP_W-1:0] recip;
		logic [STEP_W-1:0]  step;
	} dlr_cfg_t;

	typedef struct packed {
		dlr_state_t         state;
		logic               primed;
		logic [PHASE_W-1:0] phase;
	} dlr_status_t;

endpackage

`default_nettype wire

[sv/dlr_mul.sv]
`default_nettype none

module dlr_mul #(
	parameter int A_W = 19,
	parameter int B_W = 18
) (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [A_W-1:0]   a,
	input  wire logic signed [B_W-1:0]   b,
	output logic signed [A_W+B_W-1:0]    p_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
		end
	end

endmodule

`default_nettype wire

[sv/dlr_ctrl.sv]
`default_nettype none

module dlr_ctrl #(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire dlr_pkg::dlr_cfg_t              cfg,
	input  wire logic                           smp_valid,
	output logic                                smp_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]  sample_in,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output logic signed [SAMPLE_BITS-1:0]       sample_out,
	output logic                                last_of_run,
	output dlr_pkg::dlr_status_t                status
);
	import dlr_pkg::*;

	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_CHANNELS);
	localparam int POS_W  = $clog2(MAX_CHANNELS + 1);
	localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int A_W    = (SUM_W > DIFF_W) ? SUM_W : DIFF_W;
	localparam int B_W    = RECIP_W + 1;
	localparam int P_W    = A_W + B_W;
	localparam int T_W    = P_W + 1;
	localparam logic signed [T_W-1:0] SAT_HI = T_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [T_W-1:0] SAT_LO = ~SAT_HI;

	dlr_state_t                  state_q, state_d;
	logic signed [SUM_W-1:0]     frame_sum_q, sum_next;
	logic [POS_W-1:0]            pos_q, pos_inc;
	logic signed [SAMPLE_BITS-1:0] prev_q, cur_q, res_data_q, y;
	logic                        primed_q, res_valid_q, res_last_q;
	logic [PHASE_W-1:0]          phase_q, phase_sum;
	logic                        accept, frame_done, emit, finish, out_free, mul_en, last_emit;
	logic signed [A_W-1:0]       mul_a;
	logic signed [B_W-1:0]       mul_b;
	logic signed [P_W-1:0]       mul_p;
	logic signed [DIFF_W-1:0]    diff;
	logic signed [T_W-1:0]       t_sum, t_shift;

	dlr_mul #(
		.A_W(A_W),
		.B_W(B_W)
	) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_s1(mul_p)
	);

	assign smp_ready  = (state_q == ST_IDLE);
	assign accept     = smp_valid && smp_ready;
	assign pos_inc    = pos_q + POS_W'(1);
	assign frame_done = CMP_W'(pos_inc) >= CMP_W'(cfg.count);
	assign sum_next   = frame_sum_q + SUM_W'(sample_in);
	assign diff       = DIFF_W'(cur_q) - DIFF_W'(prev_q);
	assign phase_sum  = phase_q + cfg.step;
	assign last_emit  = phase_sum >= ONE_Q16;
	assign out_free   = !res_valid_q || res_ready;

	always_comb begin
		if (state_q == ST_MONO_MUL) begin
			mul_a = A_W'(frame_sum_q);
			mul_b = B_W'(cfg.recip);
		end else begin
			mul_a = A_W'(diff);
			mul_b = B_W'(phase_q[FRAC_BITS-1:0]);
		end
	end

	// The interpolation result adds the previous sample in Q16 on top of the product.
	assign t_sum   = T_W'(mul_p) + ((state_q == ST_INT_OUT) ?
			(T_W'(prev_q) <<< FRAC_BITS) : T_W'(0));
	assign t_shift = t_sum >>> FRAC_BITS;
	assign y = (t_shift > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
			(t_shift < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(t_shift);

	always_comb begin
		state_d = state_q;
		mul_en  = 1'b0;
		emit    = 1'b0;
		finish  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && frame_done) begin
					state_d = ST_MONO_MUL;
				end
			end
			ST_MONO_MUL: begin
				mul_en  = 1'b1;
				state_d = ST_MONO_SAT;
			end
			ST_MONO_SAT: begin
				state_d = primed_q ? ST_INT_MUL : ST_IDLE;
			end
			ST_INT_MUL: begin
				if (phase_q >= ONE_Q16) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					mul_en  = 1'b1;
					state_d = ST_INT_OUT;
				end
			end
			ST_INT_OUT: begin
				if (out_free) begin
					emit = 1'b1;
					if (last_emit) begin
						finish  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_INT_MUL;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			frame_sum_q <= '0;
			pos_q       <= '0;
			prev_q      <= '0;
			cur_q       <= '0;
			primed_q    <= 1'b0;
			phase_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				frame_sum_q <= sum_next;
				pos_q       <= frame_done ? '0 : pos_inc;
			end
			if (state_q == ST_MONO_SAT) begin
				frame_sum_q <= '0;
				if (primed_q) begin
					cur_q <= y;
				end else begin
					prev_q   <= y;
					primed_q <= 1'b1;
					phase_q  <= '0;
				end
			end
			if (finish) begin
				prev_q  <= cur_q;
				phase_q <= (emit ? phase_sum : phase_q) - ONE_Q16;
			end else if (emit) begin
				phase_q <= phase_sum;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_data_q <= y;
			res_last_q <= last_emit;
		end
	end

	assign res_valid     = res_valid_q;
	assign sample_out    = res_data_q;
	assign last_of_run   = res_last_q;
	assign status.state  = state_q;
	assign status.primed = primed_q;
	assign status.phase  = phase_q;

endmodule

`default_nettype wire

[sv/downmix_linear_resampler_unit.sv]
// Channel  Signals                                  Beat
// smp      smp_valid, smp_ready, sample_in          one channel sample of a frame
// res      res_valid, res_ready, sample_out,        one output sample at the target rate
//          last_of_run
// cfg      cfg_we, cfg_index, cfg_wdata             one register write, taken at once
//
// A sample that does not close a frame is taken in ST_IDLE alone. A closing sample
// then runs the downmix in ST_MONO_MUL and ST_MONO_SAT, then ST_INT_MUL and ST_INT_OUT
// for each of its 0 to 16 outputs, or ST_INT_MUL alone when none is due; the very
// first mono sample stops after the downmix. The single shared multiplier serves
// both the downmix and the interpolation; smp_ready is low outside ST_IDLE.
// The output register holds a beat while res_ready is low; the sequencer waits.
// Reset restores the register defaults and all state but the output data; no clearing pass.
`default_nettype none

`include "downmix_linear_resampler_unit_defines.svh"

module downmix_linear_resampler_unit #(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [dlr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [dlr_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  wire logic                                 smp_valid,
	output logic                                      smp_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]        sample_in,
	output logic                                      res_valid,
	input  wire logic                                 res_ready,
	output logic signed [SAMPLE_BITS-1:0]             sample_out,
	output logic                                      last_of_run
);
	import dlr_pkg::*;

	logic [CNT_W-1:0]   count_q, count_eff;
	logic [RECIP_W-1:0] recip_q;
	logic [STEP_W-1:0]  step_q, step_eff;
	dlr_cfg_t           cfg;
	dlr_status_t        status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_RESET;
			recip_q <= RECIP_RESET;
			step_q  <= STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHANNEL_COUNT: count_q <= cfg_wdata[CNT_W-1:0];
				CFG_DOWNMIX_RECIP: recip_q <= cfg_wdata[RECIP_W-1:0];
				CFG_RESAMPLE_STEP: step_q  <= cfg_wdata[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (count_q == '0) begin
			count_eff = CNT_W'(1);
		end else if ({1'b0, count_q} > (CNT_W + 1)'(MAX_CHANNELS)) begin
			count_eff = CNT_W'(MAX_CHANNELS);
		end else begin
			count_eff = count_q;
		end
		if (step_q < STEP_MIN) begin
			step_eff = STEP_MIN;
		end else if (step_q > STEP_MAX) begin
			step_eff = STEP_MAX;
		end else begin
			step_eff = step_q;
		end
	end

	assign cfg.count = count_eff;
	assign cfg.recip = recip_q;
	assign cfg.step  = step_eff;

	dlr_ctrl #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.smp_valid  (smp_valid),
		.smp_ready  (smp_ready),
		.sample_in  (sample_in),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.sample_out (sample_out),
		.last_of_run(last_of_run),
		.status     (status)
	);

	`DLR_ASSERT(a_out_phase, clk, arst_n, (status.state == ST_INT_OUT) |-> (status.phase < ONE_Q16), "output issued past the current sample")
	`DLR_ASSERT(a_unprimed_phase, clk, arst_n, !status.primed |-> (status.phase == '0), "phase moved before the first mono sample")
	`DLR_ASSERT(a_res_source, clk, arst_n, $rose(res_valid) |-> ($past(status.state) == ST_INT_OUT), "result beat not from the interpolation step")
	`DLR_ASSERT_NEXT(a_stall_hold, clk, arst_n, res_valid && !res_ready && (status.state == ST_INT_OUT), status.state == ST_INT_OUT, "sequencer ran past a stalled result")

endmodule

`default_nettype wire
